/* rtl/qlbs_pkg.sv */
// Shared types and constants of the queued LED blink sequencer.
`timescale 1ns / 1ps

package qlbs_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF     = 2'd2;

  // An on time of all ones keeps the LED lit with no deadline.
  localparam logic [TIME_W-1:0] ON_LATCH = '1;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_ON   = 2'd1,
    PHASE_OFF  = 2'd2
  } phase_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_TICK = 1'b1
  } op_kind_t;

  typedef enum logic {
    BS_WAIT = 1'b0,
    BS_READ = 1'b1
  } back_state_t;

  // One classified word from the front. A push carries {off, on} in the
  // payload, a tick carries the current time in the low half.
  typedef struct packed {
    op_kind_t    kind;
    logic [63:0] payload;
  } op_t;

  // Result word, listed from the highest bit down.
  typedef struct packed {
    logic [3:0] queued_count;
    logic [1:0] phase_now;
    logic       pin_level;
    logic       led_lit;
    logic       accepted;
  } result_t;

endpackage

/* rtl/qlbs_front.sv */
// Front end: takes input words, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module qlbs_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [qlbs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tuser,
  output logic                               op_valid,
  input  logic                               op_ready,
  output qlbs_pkg::op_t                      op
);

  qlbs_pkg::op_t slot [2];
  qlbs_pkg::op_t op_in;
  logic [1:0]    count;
  logic          wp;
  logic          rp;
  logic          push;
  logic          pop;

  assign s_axis_tready = (count != 2'd2);
  assign op_valid      = (count != 2'd0);
  assign op            = slot[rp];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = op_valid && op_ready;

  always_comb begin
    if (s_axis_tuser) begin
      op_in.kind    = qlbs_pkg::OP_TICK;
      op_in.payload = {32'd0, s_axis_tdata[95:64]};
    end else begin
      op_in.kind    = qlbs_pkg::OP_PUSH;
      op_in.payload = s_axis_tdata[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= op_in;
    end
  end

endmodule

/* rtl/qlbs_cmd_fifo.sv */
// Command queue memory with read and write pointers and a fill count.
`timescale 1ns / 1ps

module qlbs_cmd_fifo #(
  parameter int DEPTH = qlbs_pkg::QUEUE_DEPTH_DEF,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [63:0]      wr_data,
  input  logic             rd_en,
  output logic [63:0]      rd_data,
  output logic [CNT_W-1:0] count,
  output logic             full
);

  logic [63:0]      mem [DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;

  assign full = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wp <= (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd_en) begin
        rp <= (rp == PTR_W'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
  end

  // Read data stays put until the next read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rp];
    end
  end

endmodule

/* rtl/qlbs_back.sv */
// Back end: command queue, blink phase sequencer, configuration and result register.
`timescale 1ns / 1ps

module qlbs_back #(
  parameter int QUEUE_DEPTH = qlbs_pkg::QUEUE_DEPTH_DEF,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [qlbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qlbs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                op_valid,
  output logic                                op_ready,
  input  qlbs_pkg::op_t                       op,
  output logic                                res_valid,
  input  logic                                res_ready,
  output qlbs_pkg::result_t                   res
);

  logic                               enabled;
  logic                               active_high;
  logic [qlbs_pkg::TIME_W-1:0]        min_off;

  qlbs_pkg::back_state_t              state;
  qlbs_pkg::back_state_t              state_next;
  qlbs_pkg::phase_t                   phase;
  qlbs_pkg::phase_t                   phase_next;
  logic                               led;
  logic                               led_next;
  logic [qlbs_pkg::TIME_W-1:0]        deadline;
  logic [qlbs_pkg::TIME_W-1:0]        deadline_next;
  logic [qlbs_pkg::TIME_W-1:0]        cur_off;
  logic [qlbs_pkg::TIME_W-1:0]        cur_off_next;

  logic                               fifo_wr;
  logic                               fifo_rd;
  logic [63:0]                        fifo_rd_data;
  logic [CNT_W-1:0]                   fifo_count;
  logic                               fifo_full;

  logic [qlbs_pkg::TIME_W-1:0]        now;
  logic [qlbs_pkg::TIME_W-1:0]        diff;
  logic                               expired;
  logic [qlbs_pkg::TIME_W-1:0]        off_sel;
  logic [qlbs_pkg::TIME_W-1:0]        cmd_on;
  logic [qlbs_pkg::TIME_W-1:0]        cmd_off;
  logic                               out_free;
  logic                               out_load;
  logic                               acc;
  logic [CNT_W-1:0]                   cnt_after;
  logic [31:0]                        cnt_ext;
  qlbs_pkg::result_t                  res_next;

  qlbs_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fifo_wr),
    .wr_data (op.payload),
    .rd_en   (fifo_rd),
    .rd_data (fifo_rd_data),
    .count   (fifo_count),
    .full    (fifo_full)
  );

  assign now      = op.payload[31:0];
  // Wrap-safe deadline: expired once (now - deadline) is not negative.
  assign diff     = now - deadline;
  assign expired  = ~diff[31];
  assign off_sel  = (cur_off != '0) ? cur_off : min_off;
  assign cmd_on   = fifo_rd_data[31:0];
  assign cmd_off  = fifo_rd_data[63:32];
  assign out_free = ~res_valid || res_ready;

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    led_next      = led;
    deadline_next = deadline;
    cur_off_next  = cur_off;
    fifo_wr       = 1'b0;
    fifo_rd       = 1'b0;
    op_ready      = 1'b0;
    out_load      = 1'b0;
    acc           = 1'b0;
    unique case (state)
      qlbs_pkg::BS_WAIT: begin
        if (op_valid && out_free) begin
          if (op.kind == qlbs_pkg::OP_PUSH) begin
            fifo_wr  = ~fifo_full;
            acc      = ~fifo_full;
            op_ready = 1'b1;
            out_load = 1'b1;
          end else if (!enabled) begin
            op_ready = 1'b1;
            out_load = 1'b1;
          end else begin
            unique case (phase)
              qlbs_pkg::PHASE_ON: begin
                if (expired) begin
                  led_next      = 1'b0;
                  deadline_next = now + off_sel;
                  phase_next    = qlbs_pkg::PHASE_OFF;
                end
                op_ready = 1'b1;
                out_load = 1'b1;
              end
              qlbs_pkg::PHASE_OFF: begin
                if (expired) begin
                  phase_next = qlbs_pkg::PHASE_IDLE;
                end
                op_ready = 1'b1;
                out_load = 1'b1;
              end
              qlbs_pkg::PHASE_IDLE: begin
                // A pop waits in BS_READ for the registered memory read.
                if (fifo_count != '0) begin
                  fifo_rd    = 1'b1;
                  state_next = qlbs_pkg::BS_READ;
                end else begin
                  op_ready = 1'b1;
                  out_load = 1'b1;
                end
              end
              default: begin
                op_ready = 1'b1;
                out_load = 1'b1;
              end
            endcase
          end
        end
      end
      qlbs_pkg::BS_READ: begin
        if (out_free) begin
          cur_off_next = cmd_off;
          if (cmd_on == qlbs_pkg::ON_LATCH) begin
            led_next   = 1'b1;
            phase_next = qlbs_pkg::PHASE_IDLE;
          end else if (cmd_on == '0) begin
            led_next   = 1'b0;
            phase_next = qlbs_pkg::PHASE_IDLE;
          end else begin
            led_next      = 1'b1;
            deadline_next = now + cmd_on;
            phase_next    = qlbs_pkg::PHASE_ON;
          end
          op_ready   = 1'b1;
          out_load   = 1'b1;
          state_next = qlbs_pkg::BS_WAIT;
        end
      end
    endcase
  end

  assign cnt_after = fifo_count + CNT_W'(fifo_wr);
  assign cnt_ext   = 32'(cnt_after);

  always_comb begin
    res_next.accepted     = acc;
    res_next.led_lit      = led_next;
    res_next.pin_level    = active_high ? led_next : ~led_next;
    res_next.phase_now    = 2'(phase_next);
    res_next.queued_count = cnt_ext[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qlbs_pkg::BS_WAIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled     <= 1'b0;
      active_high <= 1'b1;
      min_off     <= '0;
      phase       <= qlbs_pkg::PHASE_IDLE;
      led         <= 1'b0;
      deadline    <= '0;
      cur_off     <= '0;
      res_valid   <= 1'b0;
    end else begin
      phase    <= phase_next;
      deadline <= deadline_next;
      cur_off  <= cur_off_next;
      // Enabling the block is its init step and turns the LED off.
      if (cfg_we && cfg_index == qlbs_pkg::CFG_ENABLED && cfg_wdata[0]) begin
        led <= 1'b0;
      end else begin
        led <= led_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          qlbs_pkg::CFG_ENABLED:     enabled     <= cfg_wdata[0];
          qlbs_pkg::CFG_ACTIVE_HIGH: active_high <= cfg_wdata[0];
          qlbs_pkg::CFG_MIN_OFF:     min_off     <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= res_next;
    end
  end

  a_read_only_when_idle : assert property (@(posedge clk) disable iff (rst)
    state == qlbs_pkg::BS_READ |-> phase == qlbs_pkg::PHASE_IDLE && enabled)
    else $error("command read outside the idle phase");

  a_pop_lowers_count : assert property (@(posedge clk) disable iff (rst)
    fifo_rd |=> fifo_count + CNT_W'(1) == $past(fifo_count))
    else $error("command pop did not lower the fill count");

  a_result_matches_state : assert property (@(posedge clk) disable iff (rst)
    out_load |=> res.phase_now == 2'(phase) && res.led_lit == led)
    else $error("result word does not match the sequencer state");

  a_load_only_when_free : assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free && op_valid)
    else $error("result loaded over a word still waiting");

endmodule

/* rtl/queued_led_blink_sequencer.sv */
// Top level of the queued LED blink sequencer: front end and back end.
`timescale 1ns / 1ps

// Channel   Direction  Word
// s_axis    in         tdata: on_time_ms, off_time_ms, now_ms; tuser: mode
// m_axis    out        tdata: accepted, led_lit, pin_level, phase_now, queued_count
// cfg       in         write enable, register index, write data
//
// A push, a disabled tick and a tick that only times a phase finish in BS_WAIT;
// a tick that pops a command also passes BS_READ for the registered read of the
// command memory. The front queue holds two words, so input is taken while the
// back end waits on a stalled result. Reset is synchronous; no clearing pass is
// needed, since commands are read only after being written.
module queued_led_blink_sequencer #(
  parameter int QUEUE_DEPTH = qlbs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] on_time_ms, [63:32] off_time_ms, [95:64] now_ms
  input  logic [qlbs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] mode
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] accepted, [1] led_lit, [2] pin_level, [4:3] phase_now, [8:5] queued_count
  output logic [qlbs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [qlbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qlbs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic              op_valid;
  logic              op_ready;
  qlbs_pkg::op_t     op;
  qlbs_pkg::result_t res;

  qlbs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .op_valid      (op_valid),
    .op_ready      (op_ready),
    .op            (op)
  );

  qlbs_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {7'd0, res};

endmodule
